@@ sv/smt_pkg.sv @@
// Package for the segment map translator.
// Holds controller states, result status codes, request opcodes, field widths and the extent entry type.
// No dependencies.
package smt_pkg;

  localparam int unsigned OFS_W = 48;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned ST_W  = 3;

  // result status codes
  localparam logic [ST_W-1:0] STAT_PIECE    = 3'd0;
  localparam logic [ST_W-1:0] STAT_PAST_END = 3'd1;
  localparam logic [ST_W-1:0] STAT_APPENDED = 3'd2;
  localparam logic [ST_W-1:0] STAT_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] STAT_FULL     = 3'd4;

  // request opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_PIECE_RD,
    ST_PIECE_EMIT
  } ctrl_state_t;

  // one extent table entry
  typedef struct packed {
    logic [OFS_W-1:0] vstart;
    logic [OFS_W-1:0] sstart;
    logic [LEN_W-1:0] len;
  } extent_t;

endpackage

@@ sv/segment_map_translator.sv @@
// Segment map translator top level: extent table memory, search and piece sequencer.
// Depends on smt_pkg.
//
// Ordered scatter-gather extent map. Appends (in_tuser = 0) clip the source range
// to the configured source size and record one extent at the end of the virtual
// stream; a read (in_tuser = 1) binary-searches the extent that holds the virtual
// offset and emits one source-read piece per extent touched, tlast on the final one.
// Every request gives at least one result. Timing is set by the registered read of
// the extent table memory: an append is answered from the decode state; a read decodes,
// then reads and compares once per search step (up to ceil(log2(extent count)) steps),
// then reads and emits once per piece, and waits while the result side holds off a result.
// The result register lets the next request be accepted while a result waits.
// The table needs no clearing after reset: only entries below the count are read.
module segment_map_translator
  import smt_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: source_size
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [47:0]  cfg_data,
  // request stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // start_offset[47:0], byte_count[79:48]
  input  logic         in_tuser,   // opcode
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // status[2:0], source_offset[50:3], piece_length[82:51],
                                   // buffer_offset[114:83], total_size[162:115], zero pad
  output logic         out_tlast   // last
);

  localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);

  // control and state registers
  ctrl_state_t      state_r, state_nxt;
  logic [47:0]      source_size_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [47:0]      total_r, total_nxt;

  // request registers
  logic             op_r;
  logic [47:0]      ofs_r;
  logic [31:0]      cnt_r;

  // search and sequencing
  logic [IW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [31:0]      remain_r, remain_nxt, buf_r, buf_nxt;
  logic             first_r, first_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       o_stat_r, o_stat_nxt;
  logic [47:0]      o_so_r, o_so_nxt, o_tot_r, o_tot_nxt;
  logic [31:0]      o_len_r, o_len_nxt, o_buf_r, o_buf_nxt;
  logic             o_last_r, o_last_nxt;

  // memory
  extent_t          mem [MAX_EXTENTS];
  extent_t          rdata_r, wdata;
  logic             we;
  logic [IW-1:0]    raddr;

  logic             slot_free, accept;

  assign slot_free = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // extent table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[count_r[IW-1:0]] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // append arithmetic
  logic [48:0] end_full;
  logic [47:0] end_clip, app_len_w;
  logic        app_empty, app_full;
  assign end_full  = {1'b0, ofs_r} + {17'd0, cnt_r};
  assign end_clip  = (end_full > {1'b0, source_size_r}) ? source_size_r : end_full[47:0];
  assign app_empty = (ofs_r >= end_clip);
  assign app_full  = (count_r == CW'(MAX_EXTENTS));
  assign app_len_w = end_clip - ofs_r;

  // search midpoint
  logic [IW:0] span;
  assign span = {1'b0, hi_r} - {1'b0, lo_r} + {{IW{1'b0}}, 1'b1};

  // piece arithmetic on the fetched entry
  logic [47:0] ext_ofs;
  logic [31:0] plen, len_avail;
  logic        wrap_len;
  logic [31:0] rem_after;
  logic [CW:0] idx_inc;
  assign ext_ofs   = ofs_r - rdata_r.vstart;
  assign wrap_len  = first_r && (ext_ofs > {16'd0, rdata_r.len});
  assign len_avail = first_r ? (rdata_r.len - ext_ofs[31:0]) : rdata_r.len;
  assign plen      = (wrap_len || (len_avail > remain_r)) ? remain_r : len_avail;
  assign rem_after = remain_r - plen;
  assign idx_inc   = {1'b0, idx_r} + {{CW{1'b0}}, 1'b1};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (op_r == OP_APPEND || ofs_r >= total_r || count_r == '0) begin
          if (slot_free) state_nxt = ST_IDLE;
        end else if (count_r > {{(CW-1){1'b0}}, 1'b1}) begin
          state_nxt = ST_SRCH_RD;
        end else begin
          state_nxt = ST_PIECE_RD;
        end
      end
      ST_SRCH_RD: state_nxt = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (lo_nxt < hi_nxt) state_nxt = ST_SRCH_RD;
        else                 state_nxt = ST_PIECE_RD;
      end
      ST_PIECE_RD: state_nxt = ST_PIECE_EMIT;
      ST_PIECE_EMIT: begin
        if (slot_free) state_nxt = o_last_nxt ? ST_IDLE : ST_PIECE_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    total_nxt     = total_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    remain_nxt    = remain_r;
    buf_nxt       = buf_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_stat_nxt    = o_stat_r;
    o_so_nxt      = o_so_r;
    o_len_nxt     = o_len_r;
    o_buf_nxt     = o_buf_r;
    o_tot_nxt     = o_tot_r;
    o_last_nxt    = 1'b1;
    we            = 1'b0;
    wdata         = '{vstart: total_r, sstart: ofs_r, len: app_len_w[31:0]};
    raddr         = idx_r[IW-1:0];

    unique case (state_r)
      ST_DECODE: begin
        if (op_r == OP_APPEND) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            o_so_nxt      = '0;
            o_len_nxt     = '0;
            o_buf_nxt     = '0;
            o_tot_nxt     = total_r;
            if (app_empty) begin
              o_stat_nxt = STAT_EMPTY;
            end else if (app_full) begin
              o_stat_nxt = STAT_FULL;
            end else begin
              we         = 1'b1;
              count_nxt  = count_r + {{(CW-1){1'b0}}, 1'b1};
              total_nxt  = total_r + {16'd0, app_len_w[31:0]};
              o_stat_nxt = STAT_APPENDED;
              o_so_nxt   = ofs_r;
              o_len_nxt  = app_len_w[31:0];
              o_tot_nxt  = total_nxt;
            end
          end
        end else if (ofs_r >= total_r || count_r == '0) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            o_stat_nxt    = STAT_PAST_END;
            o_so_nxt      = '0;
            o_len_nxt     = '0;
            o_buf_nxt     = '0;
            o_tot_nxt     = total_r;
          end
        end else begin
          // start search over [0, count-1]
          lo_nxt     = '0;
          hi_nxt     = IW'(count_r - {{(CW-1){1'b0}}, 1'b1});
          idx_nxt    = '0;
          remain_nxt = cnt_r;
          buf_nxt    = '0;
          first_nxt  = 1'b1;
        end
      end
      ST_SRCH_RD: begin
        mid_nxt = lo_r + IW'(span >> 1);
        raddr   = mid_nxt;
      end
      ST_SRCH_CMP: begin
        if (rdata_r.vstart <= ofs_r) lo_nxt = mid_r;
        else                         hi_nxt = mid_r - {{(IW-1){1'b0}}, 1'b1};
        idx_nxt = {{(CW-IW){1'b0}}, lo_nxt};
      end
      ST_PIECE_EMIT: begin
        o_last_nxt = (rem_after == '0) || (idx_inc >= {1'b0, count_r});
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_stat_nxt    = STAT_PIECE;
          o_so_nxt      = first_r ? (rdata_r.sstart + ext_ofs) : rdata_r.sstart;
          o_len_nxt     = plen;
          o_buf_nxt     = buf_r;
          o_tot_nxt     = total_r;
          remain_nxt    = rem_after;
          buf_nxt       = buf_r + plen;
          first_nxt     = 1'b0;
          idx_nxt       = idx_inc[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      source_size_r <= '0;
      count_r       <= '0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) source_size_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tuser;
      ofs_r <= in_tdata[47:0];
      cnt_r <= in_tdata[79:48];
    end
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    idx_r    <= idx_nxt;
    remain_r <= remain_nxt;
    buf_r    <= buf_nxt;
    first_r  <= first_nxt;
    if (slot_free && out_valid_nxt) begin
      o_stat_r <= o_stat_nxt;
      o_so_r   <= o_so_nxt;
      o_len_r  <= o_len_nxt;
      o_buf_r  <= o_buf_nxt;
      o_tot_r  <= o_tot_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, o_tot_r, o_buf_r, o_len_r, o_so_r, o_stat_r};
  assign out_tlast  = o_last_r;

endmodule

@@ tb/tb.sv @@
// Testbench for segment_map_translator: directed and random appends and reads with scoreboard.
// Depends on smt_pkg and the segment_map_translator RTL; reads no files.
`timescale 1ns / 100ps

import smt_pkg::*;

localparam int unsigned TB_MAX_EXTENTS = 64;

// one expected result of a request
typedef struct {
  logic [ST_W-1:0]  status;
  logic [OFS_W-1:0] src_ofs;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] dst_ofs;
  logic [OFS_W-1:0] total;
  logic             last;
} piece_t;

// Extent map shadow: predicts the result stream of each accepted request
class extent_scoreboard;
  logic [OFS_W-1:0] vstart [TB_MAX_EXTENTS];
  logic [OFS_W-1:0] sstart [TB_MAX_EXTENTS];
  logic [LEN_W-1:0] elen   [TB_MAX_EXTENTS];
  int unsigned      used;
  logic [OFS_W-1:0] total;
  logic [OFS_W-1:0] source_size;
  piece_t           pending[$];
  int               errors;
  int               n_req, n_stored, n_empty, n_full, n_reads, n_past, n_pieces;

  function new();
    used        = 0;
    total       = '0;
    source_size = '0;
    errors      = 0;
    n_req = 0; n_stored = 0; n_empty = 0; n_full = 0;
    n_reads = 0; n_past = 0; n_pieces = 0;
  endfunction

  function void report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endfunction

  function void push(logic [ST_W-1:0] st, logic [OFS_W-1:0] so, logic [LEN_W-1:0] pl,
                     logic [LEN_W-1:0] bo, logic last);
    piece_t p;
    p.status  = st;
    p.src_ofs = so;
    p.len     = pl;
    p.dst_ofs = bo;
    p.total   = total;
    p.last    = last;
    pending.push_back(p);
  endfunction

  // work out the expected results of one accepted request
  function void note_request(logic op, logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] cnt);
    logic [63:0] stop, rem, ext_ofs, plen, dst;
    int unsigned lo, hi, mid, idx, k;
    n_req++;
    if (op == OP_APPEND) begin
      stop = 64'(ofs) + 64'(cnt);
      if (stop > 64'(source_size)) stop = 64'(source_size);
      if (64'(ofs) >= stop) begin
        n_empty++;
        push(STAT_EMPTY, '0, '0, '0, 1'b1);
      end else if (used >= TB_MAX_EXTENTS) begin
        n_full++;
        push(STAT_FULL, '0, '0, '0, 1'b1);
      end else begin
        n_stored++;
        vstart[used] = total;
        sstart[used] = ofs;
        elen[used]   = LEN_W'(stop - 64'(ofs));
        total        = OFS_W'(64'(total) + (stop - 64'(ofs)));
        push(STAT_APPENDED, ofs, elen[used], '0, 1'b1);
        used++;
      end
      return;
    end
    n_reads++;
    if (ofs >= total || used == 0) begin
      n_past++;
      push(STAT_PAST_END, '0, '0, '0, 1'b1);
      return;
    end
    // binary search: last extent whose virtual start is at or below ofs
    lo = 0;
    hi = used - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (vstart[mid] <= ofs) lo = mid;
      else hi = mid - 1;
    end
    idx     = lo;
    ext_ofs = 64'(ofs) - 64'(vstart[idx]);
    rem     = 64'(cnt);
    dst     = '0;
    k       = 0;
    // one piece per extent touched; the first may start inside its extent
    do begin
      plen = 64'(elen[idx]) - ext_ofs;
      if (plen > rem) plen = rem;
      rem = rem - plen;
      push(STAT_PIECE, OFS_W'(64'(sstart[idx]) + ext_ofs), LEN_W'(plen), LEN_W'(dst),
           (rem == 0) || (idx + 1 >= used));
      n_pieces++;
      k++;
      dst     = dst + plen;
      idx++;
      ext_ofs = '0;
    end while (idx < used && rem > 0 && k < TB_MAX_EXTENTS);
  endfunction

  // compare one accepted result against the oldest expectation
  function void check_result(logic [ST_W-1:0] st, logic [OFS_W-1:0] so, logic [LEN_W-1:0] pl,
                             logic [LEN_W-1:0] bo, logic [OFS_W-1:0] tot, logic last);
    piece_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result status=%0d src=%0h len=%0h", st, so, pl));
      return;
    end
    e = pending.pop_front();
    if (st !== e.status)
      report($sformatf("status got %0d want %0d", st, e.status));
    if (so !== e.src_ofs)
      report($sformatf("source_offset got %0h want %0h", so, e.src_ofs));
    if (pl !== e.len)
      report($sformatf("piece_length got %0h want %0h", pl, e.len));
    if (bo !== e.dst_ofs)
      report($sformatf("buffer_offset got %0h want %0h", bo, e.dst_ofs));
    if (tot !== e.total)
      report($sformatf("total_size got %0h want %0h", tot, e.total));
    if (last !== e.last)
      report($sformatf("last got %0b want %0b", last, e.last));
  endfunction
endclass

module tb;

  localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [47:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  in_tdata;   // start_offset[47:0], byte_count[79:48]
  logic         in_tuser;   // opcode
  logic         out_tvalid;
  logic         out_tready;
  logic [167:0] out_tdata;  // status, source_offset, piece_length, buffer_offset, total_size
  logic         out_tlast;  // last

  logic calm;  // set during the stretch with no idling on either side

  extent_scoreboard sb;

  segment_map_translator #(
    .MAX_EXTENTS(TB_MAX_EXTENTS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side backpressure
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 13);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[2:0], out_tdata[50:3], out_tdata[82:51],
                      out_tdata[114:83], out_tdata[162:115], out_tlast);
  end

  function automatic logic [OFS_W-1:0] rand48();
    return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
  endfunction

  // present one request, with random idle cycles ahead of it
  task automatic send_request(input logic op, input logic [OFS_W-1:0] ofs,
                              input logic [LEN_W-1:0] cnt);
    while (!calm && $urandom_range(0, 99) < 13) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {cnt, ofs};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, ofs, cnt);
  endtask

  // hold off new requests until every expected result is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_source_size(input logic [OFS_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.source_size = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random request; append_pct sets the mix of appends and reads
  task automatic random_request(input int append_pct);
    logic [OFS_W-1:0] ofs;
    logic [LEN_W-1:0] cnt;
    logic [63:0]      ss, tot;
    int               sel;
    ss  = 64'(sb.source_size);
    tot = 64'(sb.total);
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < append_pct) begin
      if (ss != 0 && sel < 60)      ofs = OFS_W'(64'(rand48()) % ss);
      else if (ss > 5000 && sel < 75) ofs = OFS_W'(ss - $urandom_range(0, 5000));
      else                          ofs = rand48();
      sel = $urandom_range(0, 99);
      if (sel < 65)      cnt = $urandom_range(1, 5000);
      else if (sel < 85) cnt = $urandom;
      else               cnt = $urandom_range(0, 3);
      send_request(OP_APPEND, ofs, cnt);
    end else begin
      if (tot != 0 && sel < 60)      ofs = OFS_W'(64'(rand48()) % tot);
      else if (tot != 0 && sel < 75) ofs = OFS_W'(tot - $urandom_range(0, 2) - 1);
      else                           ofs = rand48();
      sel = $urandom_range(0, 99);
      if (sel < 40)      cnt = $urandom_range(0, 20000);
      else if (sel < 80) cnt = $urandom;
      else               cnt = '0;
      send_request(OP_READ, ofs, cnt);
    end
  endtask

  // run limit
  initial begin
    #5000000;
    $display("segment_map_translator verification failed");
    $finish;
  end

  // stimulus
  initial begin
    sb         = new();
    calm       = 1'b0;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tuser   = OP_APPEND;
    in_tdata   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty map, source size still zero after reset
    send_request(OP_READ,   48'd0,   32'd5);
    send_request(OP_APPEND, 48'd100, 32'd50);

    write_source_size(OFS_MAX);
    send_request(OP_APPEND, 48'd0,         32'd0);   // zero length
    send_request(OP_APPEND, OFS_MAX,       LEN_MAX); // clipped to nothing
    send_request(OP_APPEND, OFS_MAX - 10,  LEN_MAX); // clipped at source end
    send_request(OP_APPEND, 48'd0,         LEN_MAX); // largest extent
    send_request(OP_APPEND, 48'd12345,     32'd1);
    send_request(OP_READ,   48'd0,         32'd0);   // zero length inside stream
    send_request(OP_READ,   48'd5,         LEN_MAX); // spans two extents, ends short of stream end
    send_request(OP_READ,   48'd9,         32'd2);   // crosses an extent boundary
    send_request(OP_READ,   sb.total,      32'd1);   // exactly at end
    send_request(OP_READ,   OFS_MAX,       LEN_MAX); // far past end
    send_request(OP_READ,   sb.total - 1,  32'd0);
    send_request(OP_READ,   48'd3,         32'd4);

    write_source_size(48'd1000);
    send_request(OP_APPEND, 48'd990,  32'd20);       // clipped to ten bytes
    send_request(OP_APPEND, 48'd1000, 32'd5);        // starts at source end
    send_request(OP_APPEND, 48'd2000, 32'd1);        // starts beyond source end
    send_request(OP_READ,   48'd0,    LEN_MAX);

    // random traffic, full-size source; the middle runs without idling
    write_source_size(OFS_MAX);
    for (int n = 0; n < 50; n++) begin
      calm = (n >= 20 && n < 45);
      random_request(50);
    end
    calm = 1'b0;

    write_source_size(48'($urandom_range(4096, 1048576)));
    for (int n = 0; n < 50; n++) random_request(45);

    write_source_size('0);
    for (int n = 0; n < 12; n++) random_request(60);

    // fill the table and keep appending into a full map
    write_source_size(OFS_MAX);
    for (int n = 0; n < 50; n++) random_request(65);

    drain();
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));

    $display("Run covered %0d requests: %0d appends stored, %0d empty, %0d into a full table.",
             sb.n_req, sb.n_stored, sb.n_empty, sb.n_full);
    $display("%0d reads gave %0d pieces and %0d past-end results; %0d extents held at the end.",
             sb.n_reads, sb.n_pieces, sb.n_past, sb.used);
    if (sb.errors == 0)
      $display("segment_map_translator verification clean");
    else
      $display("segment_map_translator verification failed");
    $finish;
  end

endmodule
